@@ rtl/core/csfp_pkg.sv @@
// ----------------------------------------------------------------------------
// csfp_pkg
// shared types, character codes, result codes and filter constants of the
// status frame parser
// ----------------------------------------------------------------------------
package csfp_pkg;

  // frame store depth: no decoder reads beyond this position
  localparam int unsigned KeepBytes = 19;

  // character codes
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChEnd     = 8'h24;  // '$'
  localparam logic [7:0] ChStatus  = 8'h41;  // 'A'
  localparam logic [7:0] ChVersion = 8'h56;  // 'V'
  localparam logic [7:0] ChIrLearn = 8'h49;  // 'I'
  localparam logic [7:0] ChEncoder = 8'h45;  // 'E'
  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChR       = 8'h52;
  localparam logic [7:0] ChO       = 8'h4F;
  localparam logic [7:0] ChK       = 8'h4B;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerF  = 8'h66;

  // frame lengths with a meaning
  localparam int unsigned LenStatus  = 7;
  localparam int unsigned LenAction  = 3;
  localparam int unsigned LenVersion = 4;
  localparam int unsigned LenLearn   = 4;

  // frame type codes
  localparam logic [2:0] FtOther   = 3'd0;
  localparam logic [2:0] FtStatus  = 3'd1;
  localparam logic [2:0] FtVersion = 3'd2;
  localparam logic [2:0] FtIrLearn = 3'd3;
  localparam logic [2:0] FtEncoder = 3'd4;

  // ir event codes
  localparam logic [2:0] IrNone         = 3'd0;
  localparam logic [2:0] IrPressed      = 3'd1;
  localparam logic [2:0] IrShortRelease = 3'd2;
  localparam logic [2:0] IrLongPress    = 3'd3;
  localparam logic [2:0] IrLongRelease  = 3'd4;

  localparam logic [7:0] LongPressReset = 8'd30;
  localparam logic [8:0] HoldMax        = 9'd511;

  // voltage filter, q8 millivolts
  // first sample: (100 * b * 1325184 + 5000) / 10000
  // later:        (9900 * f + b * 1325184 + 5000) / 10000
  localparam logic [27:0] MulInit   = 28'd132518400;
  localparam logic [27:0] MulKeep   = 28'd9900;
  localparam logic [20:0] MulSample = 21'd1325184;
  localparam logic [34:0] RoundAdd  = 35'd5000;
  // x / 10000 = (x >> 4) / 625, and m / 625 = (m * Recip625) >> 41 for m < 2^31
  localparam logic [31:0] Recip625  = 32'd3518437209;
  localparam logic [21:0] VoltMax   = 22'd3379219;

  typedef struct packed {
    logic        res;          // terminator beat, gives a result
    logic        upd;          // carries a voltage sample
    logic        vinit;        // first sample since reset
    logic [7:0]  vbyte;        // decoded sample byte
    logic [2:0]  frame_type;
    logic        action_done;
    logic [2:0]  ir_event;
    logic [15:0] ir_event_key;
    logic        learn_ok;
    logic [31:0] version_word;
    logic [31:0] enc_first;
    logic [31:0] enc_second;
  } item_t;

  typedef struct packed {
    logic [2:0]         frame_type;
    logic [13:0]        voltage_mv;
    logic               action_done;
    logic [2:0]         ir_event;
    logic [15:0]        ir_event_key;
    logic               learn_ok;
    logic [31:0]        version_word;
    logic signed [31:0] enc_first;
    logic signed [31:0] enc_second;
  } result_t;

  // hex digit value, 15 for anything that is not a hex digit
  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [3:0] r;
    if (c >= ChDigit0 && c <= ChDigit9) begin
      r = c[3:0];
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      r = 4'(c - ChUpperA + 8'd10);
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      r = 4'(c - ChLowerA + 8'd10);
    end else begin
      r = 4'hF;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
    return {nib(hi), nib(lo)};
  endfunction

endpackage

@@ rtl/core/csfp_in_if.sv @@
// ----------------------------------------------------------------------------
// csfp_in_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface csfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/csfp_out_if.sv @@
// ----------------------------------------------------------------------------
// csfp_out_if
// decoded frame result channel
// ----------------------------------------------------------------------------
interface csfp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_type;
  logic [13:0]        voltage_mv;
  logic               action_done;
  logic [2:0]         ir_event;
  logic [15:0]        ir_event_key;
  logic               learn_ok;
  logic [31:0]        version_word;
  logic signed [31:0] encoder_count_first;
  logic signed [31:0] encoder_count_second;

  modport source (
    output valid, output frame_type, output voltage_mv, output action_done,
    output ir_event, output ir_event_key, output learn_ok, output version_word,
    output encoder_count_first, output encoder_count_second, input ready
  );
  modport sink (
    input valid, input frame_type, input voltage_mv, input action_done,
    input ir_event, input ir_event_key, input learn_ok, input version_word,
    input encoder_count_first, input encoder_count_second, output ready
  );
endinterface

@@ rtl/core/csfp_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// csfp_frame_decoder
// frame store, length count, ir key tracker and fixed-position field decode
// ----------------------------------------------------------------------------
module csfp_frame_decoder #(
  parameter int unsigned FRAME_CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           beat_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  output logic           item_vld_o,
  output csfp_pkg::item_t item_o
);
  import csfp_pkg::*;

  localparam int unsigned    LenW   = $clog2(FRAME_CAPACITY + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(FRAME_CAPACITY);

  logic [7:0]      store_q [KeepBytes];
  logic [7:0]      store_d [KeepBytes];
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     last_ir_q, last_ir_d;
  logic [15:0]     held_q, held_d;
  logic [8:0]      hold_q, hold_d;
  logic            vvalid_q, vvalid_d;
  logic [7:0]      lp_q, lp_d;

  logic            is_nl, is_end;
  logic [7:0]      kind;
  logic [15:0]     code, code_new;
  logic [31:0]     hw_lo, hw_hi;

  always_comb begin
    is_nl    = (rx_byte_i == ChNewline);
    is_end   = (rx_byte_i == ChEnd);
    kind     = store_q[0];
    code_new = {hex_byte(store_q[5], store_q[6]), hex_byte(store_q[3], store_q[4])};
    hw_lo    = {hex_byte(store_q[3], store_q[4]), hex_byte(store_q[5], store_q[6]),
                hex_byte(store_q[7], store_q[8]), hex_byte(store_q[9], store_q[10])};
    hw_hi    = {hex_byte(store_q[11], store_q[12]), hex_byte(store_q[13], store_q[14]),
                hex_byte(store_q[15], store_q[16]), hex_byte(store_q[17], store_q[18])};

    store_d    = store_q;
    len_d      = len_q;
    last_ir_d  = last_ir_q;
    held_d     = held_q;
    hold_d     = hold_q;
    vvalid_d   = vvalid_q;
    lp_d       = cfg_we_i ? cfg_wdata_i : lp_q;
    code       = last_ir_q;
    item_o     = '0;
    item_vld_o = beat_i && !is_nl;

    if (beat_i && !is_nl) begin
      if (!is_end) begin
        // append, bytes past capacity are dropped
        if (len_q < LenMax) begin
          for (int i = 0; i < KeepBytes; i++) begin
            if (len_q == LenW'(i)) store_d[i] = rx_byte_i;
          end
          len_d = len_q + LenW'(1);
        end
      end else begin
        item_o.res = 1'b1;
        for (int i = 0; i < KeepBytes; i++) store_d[i] = '0;
        len_d = '0;

        priority if (kind == ChStatus) begin
          item_o.frame_type  = FtStatus;
          item_o.action_done = (len_q == LenW'(LenAction));
          if (len_q == LenW'(LenStatus)) begin
            item_o.upd   = 1'b1;
            item_o.vinit = !vvalid_q;
            item_o.vbyte = hex_byte(store_q[1], store_q[2]);
            vvalid_d     = 1'b1;
            last_ir_d    = code_new;
            code         = code_new;
          end
          // press / long press / release tracking
          if (code != held_q) begin
            if (code != '0) begin
              item_o.ir_event     = IrPressed;
              item_o.ir_event_key = code;
            end else begin
              item_o.ir_event     = (hold_q >= {1'b0, lp_q}) ? IrLongRelease : IrShortRelease;
              item_o.ir_event_key = held_q;
            end
            held_d = code;
            hold_d = '0;
          end else if (code != '0) begin
            if (hold_q == {1'b0, lp_q}) begin
              item_o.ir_event     = IrLongPress;
              item_o.ir_event_key = code;
            end
            if (hold_q != HoldMax) hold_d = hold_q + 9'd1;
          end else begin
            hold_d = '0;
          end
        end else if (kind == ChVersion) begin
          if (len_q == LenW'(LenVersion)) begin
            item_o.frame_type   = FtVersion;
            item_o.version_word = {store_q[0], store_q[1], store_q[2], store_q[3]};
          end
        end else if (kind == ChIrLearn) begin
          item_o.frame_type = FtIrLearn;
          item_o.learn_ok   = (len_q == LenW'(LenLearn)) && (store_q[1] == ChR) &&
                              (store_q[2] == ChO) && (store_q[3] == ChK);
        end else if (kind == ChEncoder) begin
          if (store_q[1] == ChM && store_q[2] == ChM) begin
            item_o.frame_type = FtEncoder;
            item_o.enc_first  = 32'd0 - hw_hi;
            item_o.enc_second = 32'd0 - hw_lo;
          end
        end else begin
          item_o.frame_type = FtOther;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeepBytes; i++) store_q[i] <= '0;
      len_q     <= '0;
      last_ir_q <= '0;
      held_q    <= '0;
      hold_q    <= '0;
      vvalid_q  <= 1'b0;
      lp_q      <= LongPressReset;
    end else begin
      store_q   <= store_d;
      len_q     <= len_d;
      last_ir_q <= last_ir_d;
      held_q    <= held_d;
      hold_q    <= hold_d;
      vvalid_q  <= vvalid_d;
      lp_q      <= lp_d;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("frame length beyond capacity");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && rx_byte_i == ChEnd |=> len_q == '0)
    else $error("frame not cleared after terminator");

  a_ir_only_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_o && item_o.ir_event != IrNone |-> item_o.res && item_o.frame_type == FtStatus)
    else $error("ir event on a non-status frame");
`endif

endmodule

@@ rtl/core/csfp_result_pipe.sv @@
// ----------------------------------------------------------------------------
// csfp_result_pipe
// four-stage result pipeline holding the voltage filter, plus output register
// ----------------------------------------------------------------------------
module csfp_result_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_vld_i,
  input  csfp_pkg::item_t   item_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output csfp_pkg::result_t out_o
);
  import csfp_pkg::*;

  item_t       s1_q, s2_q, s3_q, s4_q;
  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic        s1_go, s2_go, s3_go, s4_go, out_free;
  logic [34:0] t1_q, t1_d;
  logic [28:0] t2_q, t2_d;
  logic [30:0] m_q, m_d;
  logic [21:0] q_q, q_d;
  logic [21:0] f_q, f_d;
  logic [21:0] vnew;
  logic        out_v_q;
  result_t     out_q;

  logic [21:0] a_op;
  logic [27:0] c_op;
  logic [49:0] t1_full;
  logic [34:0] num;
  logic [62:0] prod;

  // stage handshake, items move on into empty or draining stages
  always_comb begin
    out_free = !out_v_q || out_ready_i;
    s4_go    = s4_v_q && (!s4_q.res || out_free);
    s3_go    = s3_v_q && (!s4_v_q || s4_go);
    s2_go    = s2_v_q && (!s3_v_q || s3_go);
    s1_go    = s1_v_q && (!s2_v_q || s2_go);
    ready_o  = !s1_v_q || s1_go;
  end

  // filter datapath
  always_comb begin
    a_op    = s1_q.vinit ? 22'(s1_q.vbyte) : f_q;
    c_op    = s1_q.vinit ? MulInit : MulKeep;
    t1_full = 50'(a_op) * 50'(c_op);
    t1_d    = t1_full[34:0];
    t2_d    = s1_q.vinit ? '0 : 29'(s1_q.vbyte) * 29'(MulSample);
    num     = t1_q + 35'(t2_q) + RoundAdd;
    m_d     = num[34:4];
    prod    = 63'(m_q) * 63'(Recip625);
    q_d     = prod[62:41];
    vnew    = s4_q.upd ? q_q : f_q;
    f_d     = (s4_go && s4_q.upd) ? q_q : f_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      f_q     <= '0;
    end else begin
      s1_v_q  <= item_vld_i ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
      s2_v_q  <= s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_q);
      s3_v_q  <= s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_v_q);
      s4_v_q  <= s3_go ? 1'b1 : (s4_go ? 1'b0 : s4_v_q);
      if (s4_go && s4_q.res) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      f_q <= f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_vld_i) s1_q <= item_i;
    if (s1_go) begin
      s2_q <= s1_q;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
    if (s2_go) begin
      s3_q <= s2_q;
      m_q  <= m_d;
    end
    if (s3_go) begin
      s4_q <= s3_q;
      q_q  <= q_d;
    end
    if (s4_go && s4_q.res) begin
      out_q.frame_type   <= s4_q.frame_type;
      out_q.voltage_mv   <= vnew[21:8];
      out_q.action_done  <= s4_q.action_done;
      out_q.ir_event     <= s4_q.ir_event;
      out_q.ir_event_key <= s4_q.ir_event_key;
      out_q.learn_ok     <= s4_q.learn_ok;
      out_q.version_word <= s4_q.version_word;
      out_q.enc_first    <= s4_q.enc_first;
      out_q.enc_second   <= s4_q.enc_second;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // the filter state is read at stage one, so no second sample may be in flight
  a_one_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && s4_q.upd |-> !(s1_v_q && s1_q.upd) && !(s2_v_q && s2_q.upd) &&
                           !(s3_v_q && s3_q.upd))
    else $error("two voltage samples in flight");

  a_volt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && s4_q.upd |-> q_q <= VoltMax)
    else $error("filtered voltage out of range");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_ready_i && !(s4_go && s4_q.res) |=> !out_v_q)
    else $error("result delivered twice");
`endif

endmodule

@@ rtl/core/coprocessor_status_frame_parser.sv @@
// ----------------------------------------------------------------------------
// coprocessor_status_frame_parser
// parses serial coprocessor frames terminated by '$' into decoded results
// ----------------------------------------------------------------------------
//
//   channel   dir   beat                 payload
//   in_i      in    one serial byte      rx_byte
//   out_o     out   one decoded frame    frame_type .. encoder_count_second
//   cfg       in    long press setting   cfg_wdata_i on cfg_we_i
//
// one byte per cycle while in_i.ready is high; a '$' beat reaches the output register
// through sample multiply, rounding add, reciprocal divide by 10000, filter update
// reset clears the frame, the ir tracker and the filter at once, no sweep
// out_o.ready low holds the output register; the four stages keep taking bytes
// until they are full, then in_i.ready drops
//
module coprocessor_status_frame_parser #(
  parameter int unsigned FRAME_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csfp_in_if.sink    in_i,
  csfp_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import csfp_pkg::*;

  logic    beat;
  logic    ready;
  logic    item_vld;
  item_t   item;
  logic    res_vld;
  result_t res;

  // a beat is taken whenever stage one has room
  assign in_i.ready = ready;
  assign beat       = in_i.valid && ready;

  // store bytes, track keys and decode the frame on the terminator
  csfp_frame_decoder #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (in_i.rx_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_vld_o  (item_vld),
    .item_o      (item)
  );

  // voltage filter and output register
  csfp_result_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .ready_o     (ready),
    .out_valid_o (res_vld),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  // result fields onto the output channel
  assign out_o.valid                = res_vld;
  assign out_o.frame_type           = res.frame_type;
  assign out_o.voltage_mv           = res.voltage_mv;
  assign out_o.action_done          = res.action_done;
  assign out_o.ir_event             = res.ir_event;
  assign out_o.ir_event_key         = res.ir_event_key;
  assign out_o.learn_ok             = res.learn_ok;
  assign out_o.version_word         = res.version_word;
  assign out_o.encoder_count_first  = res.enc_first;
  assign out_o.encoder_count_second = res.enc_second;

endmodule
